@@ hw/rtl/bvct_pkg.sv @@
// Shared types for the bounding volume collision test.
// Holds volume kind codes and the pair test selector; no dependencies.
`default_nettype none
package bvct_pkg;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SPHERE = 2'd1,
		KIND_BOX    = 2'd2,
		KIND_PLANE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PAIR_FLAG = 3'd0,   // answer settled in stage one (none, box-box, plane-plane)
		PAIR_SS   = 3'd1,
		PAIR_SB   = 3'd2,
		PAIR_SP   = 3'd3,
		PAIR_BP   = 3'd4
	} pair_t;

endpackage
`default_nettype wire

@@ hw/rtl/bounding_volume_collision_test.sv @@
// Bounding volume collision test. Throughput one pair per cycle unless the output stalls;
// stage one orders the pair and forms differences, stage two holds the products, stage three
// sums, compares and holds the result beat.
// A result stalled at the output holds the whole pipeline; nothing is dropped or repeated.
// Reset (arst_n, asynchronous, active low) clears the valid bits only.
// Depends on bvct_pkg.
`default_nettype none
module bounding_volume_collision_test
	import bvct_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  first_kind,
	input  wire logic [47:0] first_point,
	input  wire logic [47:0] first_second,
	input  wire logic [15:0] first_scalar,
	input  wire logic [1:0]  second_kind,
	input  wire logic [47:0] second_point,
	input  wire logic [47:0] second_second,
	input  wire logic [15:0] second_scalar,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             hit
);

	localparam int CW  = COORD_WIDTH;
	localparam int PKW = 3 * CW;
	localparam int DW  = CW + 1;       // difference / operand width
	localparam int PW  = 2 * CW + 4;   // product sum width

	// unpack both volumes; bits above the 48-bit field read as zero
	logic [PKW+47:0] pt_w [2];
	logic [PKW+47:0] sc_w [2];
	logic [CW+15:0]  k_w  [2];
	logic [1:0]      kind_w [2];
	logic signed [CW-1:0] vp [2][3];
	logic signed [CW-1:0] vs [2][3];
	logic [CW-1:0]        vk [2];

	always_comb begin
		pt_w[0] = {{PKW{1'b0}}, first_point};
		pt_w[1] = {{PKW{1'b0}}, second_point};
		sc_w[0] = {{PKW{1'b0}}, first_second};
		sc_w[1] = {{PKW{1'b0}}, second_second};
		k_w[0]  = {{CW{1'b0}}, first_scalar};
		k_w[1]  = {{CW{1'b0}}, second_scalar};
		kind_w[0] = first_kind;
		kind_w[1] = second_kind;
		for (int v = 0; v < 2; v++) begin
			vk[v] = k_w[v][CW-1:0];
			for (int i = 0; i < 3; i++) begin
				vp[v][i] = pt_w[v][i*CW +: CW];
				vs[v][i] = sc_w[v][i*CW +: CW];
			end
		end
	end

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage one: order the pair so that a has the lower kind, pick operands
	logic swap;
	logic [1:0] ka, kb;
	logic signed [CW-1:0] ap [3], as_ [3], bp [3], bs [3];
	logic [CW-1:0] ak, bk;
	logic signed [DW-1:0] d0a [3], d0b [3], d1a [3], d1b [3];
	logic [DW-1:0] sq_c;
	logic signed [PW-1:0] bound_c;
	logic flag_c;
	pair_t pair_c;
	logic same_pos, same_n, opp_n, bb_ok;
	logic signed [CW-1:0] q;

	always_comb begin
		swap = kind_w[0] > kind_w[1];
		ka = swap ? kind_w[1] : kind_w[0];
		kb = swap ? kind_w[0] : kind_w[1];
		ak = swap ? vk[1] : vk[0];
		bk = swap ? vk[0] : vk[1];
		for (int i = 0; i < 3; i++) begin
			ap[i]  = swap ? vp[1][i] : vp[0][i];
			as_[i] = swap ? vs[1][i] : vs[0][i];
			bp[i]  = swap ? vp[0][i] : vp[1][i];
			bs[i]  = swap ? vs[0][i] : vs[1][i];
		end
		same_pos = 1'b1;
		same_n   = 1'b1;
		opp_n    = 1'b1;
		bb_ok    = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (ap[i] != bp[i]) same_pos = 1'b0;
			if (as_[i] != bs[i]) same_n = 1'b0;
			if (DW'(as_[i]) != -DW'(bs[i])) opp_n = 1'b0;
			if (!(ap[i] < bs[i] && as_[i] > bp[i])) bb_ok = 1'b0;
		end
		pair_c  = PAIR_FLAG;
		flag_c  = 1'b0;
		sq_c    = DW'(ak);
		bound_c = '0;
		q       = '0;
		for (int i = 0; i < 3; i++) begin
			d0a[i] = DW'(ap[i]) - DW'(bp[i]);
			d0b[i] = d0a[i];
			d1a[i] = '0;
			d1b[i] = '0;
		end
		if (ka == KIND_SPHERE && kb == KIND_SPHERE) begin
			pair_c = PAIR_SS;
			sq_c   = DW'(ak) + DW'(bk);
		end else if (ka == KIND_SPHERE && kb == KIND_BOX) begin
			pair_c = PAIR_SB;
			for (int i = 0; i < 3; i++) begin
				if (ap[i] < bp[i]) q = bp[i];
				else if (ap[i] > bs[i]) q = bs[i];
				else q = ap[i];
				d0a[i] = DW'(ap[i]) - DW'(q);
				d0b[i] = d0a[i];
			end
		end else if (ka == KIND_SPHERE && kb == KIND_PLANE) begin
			pair_c  = PAIR_SP;
			bound_c = PW'({DW'(ak) + DW'(bk), 4'b0000});
			for (int i = 0; i < 3; i++) d0b[i] = DW'(bs[i]);
		end else if (ka == KIND_BOX && kb == KIND_BOX) begin
			flag_c = bb_ok;
		end else if (ka == KIND_BOX && kb == KIND_PLANE) begin
			pair_c  = PAIR_BP;
			bound_c = PW'({bk, 4'b0000});
			for (int i = 0; i < 3; i++) begin
				d0b[i] = DW'(bs[i]);
				d1a[i] = DW'(as_[i]) - DW'(bp[i]);
				d1b[i] = DW'(bs[i]);
			end
		end else if (ka == KIND_PLANE) begin
			flag_c = same_pos || (!same_n && !opp_n);
		end
	end

	logic v_s1, v_s2;
	pair_t pair_s1, pair_s2;
	logic flag_s1, flag_s2;
	logic signed [DW-1:0] d0a_s1 [3], d0b_s1 [3], d1a_s1 [3], d1b_s1 [3];
	logic [DW-1:0] sq_s1;
	logic signed [PW-1:0] bound_s1, bound_s2;
	logic signed [2*DW-1:0] p0_s2 [3], p1_s2 [3];
	logic [2*DW-1:0] sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1  <= pair_c;
			flag_s1  <= flag_c;
			sq_s1    <= sq_c;
			bound_s1 <= bound_c;
			d0a_s1   <= d0a;
			d0b_s1   <= d0b;
			d1a_s1   <= d1a;
			d1b_s1   <= d1b;
		end
	end

	// stage two: products at full width
	always_ff @(posedge clk) begin
		if (en) begin
			pair_s2  <= pair_s1;
			flag_s2  <= flag_s1;
			bound_s2 <= bound_s1;
			sq_s2    <= sq_s1 * sq_s1;
			for (int i = 0; i < 3; i++) begin
				p0_s2[i] <= d0a_s1[i] * d0b_s1[i];
				p1_s2[i] <= d1a_s1[i] * d1b_s1[i];
			end
		end
	end

	// stage three: sum and compare
	logic signed [PW-1:0] sum0, corner;
	logic signed [PW-1:0] sqx;
	logic any_corner, hit_c;

	always_comb begin
		sum0 = PW'(p0_s2[0]) + PW'(p0_s2[1]) + PW'(p0_s2[2]);
		sqx  = PW'(sq_s2);
		any_corner = 1'b0;
		for (int m = 0; m < 8; m++) begin
			corner = '0;
			for (int i = 0; i < 3; i++)
				corner = corner + (m[i] ? PW'(p1_s2[i]) : PW'(p0_s2[i]));
			if (corner <= bound_s2) any_corner = 1'b1;
		end
		case (pair_s2)
			PAIR_SS, PAIR_SB: hit_c = sum0 <= sqx;
			PAIR_SP:          hit_c = sum0 <= bound_s2;
			PAIR_BP:          hit_c = any_corner;
			default:          hit_c = flag_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) hit <= hit_c;
	end

endmodule
`default_nettype wire
